// ===== rtl/sbs_pkg.sv =====
// sbs_pkg: shared widths, item types, controller state and command/status
// structs for the sorted table binary search core
// no dependencies

package sbs_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 1024;

  localparam int CFG_W    = 11;
  localparam int INDEX_W  = 10;
  localparam int ELEM_W   = 32;
  localparam int POS_W    = 10;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef struct packed {
    logic                     func;
    logic [INDEX_W-1:0]       write_index;
    logic signed [ELEM_W-1:0] element_value;
    logic signed [ELEM_W-1:0] search_key;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PROBE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic start_load;
    logic start_search;
    logic write_mem;
    logic probe;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic probe_done;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/sorted_table_binary_search_core.sv =====
// sorted_table_binary_search_core: top level, joins the sequencer and the datapath
// depends on sbs_pkg, sbs_ctrl, sbs_datapath
//
//   channel  | handshake                     | payload
//   ---------+-------------------------------+-------------------------------
//   config   | cfg_we_i                      | cfg_wdata_i (entries in use)
//   input    | in_valid_i / in_stall_o       | in_item_i  (sbs_pkg::in_item_t)
//   output   | out_valid_o / out_stall_i     | out_item_o (sbs_pkg::out_item_t)
//
// a load does index reduction, then the table write
// a search does a start read, P probes, then the result load; P = number of probes,
//   at most clog2(count) + 1 (11 for 1024 entries); one table read per probe,
//   the read data is registered and compared in the following cycle
// reset clears the count and the result valid flag; the table is not cleared
// a finished search waits while a held result is stalled; input is taken again
//   once the result has moved into the result register

module sorted_table_binary_search_core #(
  parameter int TABLE_DEPTH = sbs_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [sbs_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  sbs_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output sbs_pkg::out_item_t         out_item_o
);

  sbs_pkg::cmd_t    cmd;
  sbs_pkg::status_t status;

  sbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_item_i.func),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

// ===== rtl/sbs_ctrl.sv =====
// sbs_ctrl: sequencer for loads and searches, drives the datapath commands
// depends on sbs_pkg

module sbs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_func_i,
  output logic              in_stall_o,
  input  sbs_pkg::status_t  status_i,
  output sbs_pkg::cmd_t     cmd_o
);

  sbs_pkg::state_e state_q, state_d;
  logic            accept;

  assign accept = in_valid_i && (state_q == sbs_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sbs_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_func_i == sbs_pkg::FUNC_LOAD) begin
            state_d = sbs_pkg::ST_LOAD;
          end else begin
            state_d = sbs_pkg::ST_PROBE;
          end
        end
      end
      sbs_pkg::ST_LOAD: begin
        state_d = sbs_pkg::ST_IDLE;
      end
      sbs_pkg::ST_PROBE: begin
        if (status_i.probe_done) begin
          state_d = sbs_pkg::ST_DONE;
        end
      end
      sbs_pkg::ST_DONE: begin
        if (status_i.out_free) begin
          state_d = sbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sbs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    case (state_q)
      sbs_pkg::ST_IDLE: begin
        in_stall_o         = 1'b0;
        cmd_o.start_load   = accept && (in_func_i == sbs_pkg::FUNC_LOAD);
        cmd_o.start_search = accept && (in_func_i == sbs_pkg::FUNC_SEARCH);
      end
      sbs_pkg::ST_LOAD: begin
        cmd_o.write_mem = 1'b1;
      end
      sbs_pkg::ST_PROBE: begin
        cmd_o.probe = 1'b1;
      end
      sbs_pkg::ST_DONE: begin
        cmd_o.load_out = status_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/sbs_datapath.sv =====
// sbs_datapath: element table, count register, probe window, index reduction
// and result register for the sorted table binary search core
// depends on sbs_pkg

module sbs_datapath #(
  parameter int TABLE_DEPTH = sbs_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sbs_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  sbs_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output sbs_pkg::out_item_t            out_item_o,
  input  sbs_pkg::cmd_t                 cmd_i,
  output sbs_pkg::status_t              status_o
);

  localparam int AddrW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CntW   = $clog2(TABLE_DEPTH + 1);
  localparam int CfgW   = sbs_pkg::CFG_W;
  localparam int SatW   = (CntW > CfgW) ? CntW : CfgW;
  localparam int IdxW   = sbs_pkg::INDEX_W;
  localparam int PosW   = sbs_pkg::POS_W;
  localparam int ElemW  = sbs_pkg::ELEM_W;
  // reciprocal for index reduction modulo the table depth
  localparam int    MulS  = IdxW + AddrW;
  localparam int    RecW  = IdxW + 2;
  localparam int    ProdW = IdxW + RecW;
  localparam int    RemW  = IdxW + CntW;
  localparam longint RecipL = ((longint'(1) << MulS) + longint'(TABLE_DEPTH) - 1)
                              / longint'(TABLE_DEPTH);
  localparam logic [RecW-1:0] Recip = RecW'(RecipL);

  logic [ElemW-1:0]        mem_q [TABLE_DEPTH];
  logic signed [ElemW-1:0] rd_data_q;

  logic [CfgW-1:0]         entries_q;
  logic [CntW-1:0]         lo_q, lo_d;
  logic [CntW-1:0]         n_q, n_d;
  logic [CntW-1:0]         mid_q, mid_d;
  logic signed [ElemW-1:0] key_q;
  logic                    hit_q;
  logic [PosW-1:0]         pos_q;
  logic                    out_valid_q;
  sbs_pkg::out_item_t      out_item_q;

  logic [ElemW-1:0]        wdata_q;
  logic [IdxW-1:0]         widx_q;
  logic [IdxW-1:0]         quot_q;

  logic [ProdW-1:0]        recip_prod;
  logic [RemW-1:0]         rem;
  logic [AddrW-1:0]        waddr;
  logic [CntW-1:0]         sat_cnt;
  logic [CntW-1:0]         half;
  logic                    eq, lt, step_hit;
  logic                    do_read;

  // count beyond the table saturates to the depth
  always_comb begin
    if (SatW'(entries_q) > SatW'(TABLE_DEPTH)) begin
      sat_cnt = CntW'(TABLE_DEPTH);
    end else begin
      sat_cnt = CntW'(entries_q);
    end
  end

  assign recip_prod = ProdW'(in_item_i.write_index) * ProdW'(Recip);
  assign rem        = RemW'(widx_q) - (RemW'(quot_q) * RemW'(TABLE_DEPTH));
  assign waddr      = rem[AddrW-1:0];

  assign half     = n_q >> 1;
  assign eq       = (key_q == rd_data_q);
  assign lt       = (key_q < rd_data_q);
  assign step_hit = (n_q != '0) && eq;

  always_comb begin
    if (cmd_i.start_search) begin
      lo_d = '0;
      n_d  = sat_cnt;
    end else if (lt) begin
      lo_d = lo_q;
      n_d  = half;
    end else begin
      lo_d = mid_q;
      n_d  = n_q - half;
    end
    mid_d = lo_d + (n_d >> 1);
  end

  assign do_read = cmd_i.start_search || cmd_i.probe;

  assign status_o.probe_done = (n_q <= CntW'(1)) || eq;
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_mem) begin
      mem_q[waddr] <= wdata_q;
    end
    if (do_read) begin
      rd_data_q <= mem_q[mid_d[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        entries_q <= cfg_wdata_i;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_load) begin
      wdata_q <= in_item_i.element_value;
      widx_q  <= in_item_i.write_index;
      quot_q  <= IdxW'(recip_prod >> MulS);
    end
    if (cmd_i.start_search) begin
      key_q <= in_item_i.search_key;
    end
    if (do_read) begin
      lo_q  <= lo_d;
      n_q   <= n_d;
      mid_q <= mid_d;
    end
    if (cmd_i.probe) begin
      hit_q <= step_hit;
      pos_q <= PosW'(mid_q);
    end
    if (cmd_i.load_out) begin
      out_item_q.found    <= hit_q;
      out_item_q.position <= hit_q ? pos_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTH
  a_probe_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.probe && (n_q != '0) |-> mid_q < CntW'(TABLE_DEPTH))
    else $error("probe address outside the table");

  a_window_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.probe && !status_o.probe_done |=> (n_q < $past(n_q)) && (n_q != '0))
    else $error("search window did not shrink");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> !out_valid_q || !out_stall_i)
    else $error("result register overwritten while held");
`endif

endmodule
